### rtl/abdt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abdt_pkg
// Shared types, constants and elaboration-time helpers for the anchor box
// decoder with score threshold.
// ----------------------------------------------------------------------------
package abdt_pkg;

    // Default width of one signed box delta inside its 16-bit lane
    localparam int DELTA_BITS = 16;

    // Configuration port
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_THRESH_Q        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SCORE_EXPONENT  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BOX_EXPONENT    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_INV_RESIZE_X    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_INV_RESIZE_Y    = 3'd4;

    localparam logic [15:0] INV_RESIZE_ONE = 16'd4096;

    // Sigmoid constants: log2(e) in Q16, |x| clamp of 16.0 in Q16
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic [20:0] SIG_CLAMP = 21'h100000;

    // exp2 of the fraction: high bits come from a table, the rest take one
    // multiply step each
    localparam int EXP_FRAC_BITS = 16;
    localparam int EXP_HI_BITS   = 8;
    localparam int EXP_LO_STAGES = EXP_FRAC_BITS - EXP_HI_BITS;
    localparam int EXP_TAB_SIZE  = 1 << EXP_HI_BITS;

    // Restoring divider: one quotient bit per stage
    localparam int DIV_STAGES = 17;

    // Register counts along the sigmoid and box paths
    localparam int SIG_LAT = 3 + EXP_LO_STAGES + 1 + DIV_STAGES;
    localparam int BOX_LAT = 6;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic signed [15:0] score_value;
        logic [63:0]        box_deltas;
        logic [7:0]         category;
        logic [7:0]         grid_y;
        logic [7:0]         grid_x;
        logic [6:0]         step_y;
        logic [6:0]         step_x;
        logic [7:0]         center_off_y;
        logic [7:0]         center_off_x;
        logic [9:0]         anc_height;
        logic [9:0]         anc_width;
    } cell_t;

    typedef struct packed {
        logic [7:0]         box_category;
        logic [15:0]        confidence;
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic signed [15:0] right;
        logic signed [15:0] bottom;
    } box_t;

    typedef struct packed {
        logic signed [15:0] thresh_q;
        logic signed [4:0]  score_exponent;
        logic signed [4:0]  box_exponent;
        logic [15:0]        inv_resize_x;
        logic [15:0]        inv_resize_y;
    } cfg_t;

    // Floor square root, used only to build constants
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        x = v;
        r = '0;
        b = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // 2^(-2^-n) in Q0.32, each constant the floor root of the one before
    function automatic logic [31:0] exp2_const(input int n);
        logic [63:0] c;
        c = 64'd1 << 31;
        for (int i = 1; i <= n; i++) begin
            c = isqrt64(c << 32);
        end
        return c[31:0];
    endfunction

    // Partial product over the high fraction bits, Q0.32 (1.0 = 2^32)
    function automatic logic [32:0] exp2_hi(input int idx);
        logic [63:0] acc;
        logic [63:0] c;
        acc = 64'd1 << 32;
        c   = 64'd1 << 31;
        for (int i = 1; i <= EXP_HI_BITS; i++) begin
            c = isqrt64(c << 32);
            if (((idx >> (EXP_HI_BITS - i)) & 1) != 0) begin
                acc = (acc * c) >> 32;
            end
        end
        return acc[32:0];
    endfunction

endpackage

### rtl/abdt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abdt_front
// Input stage: takes cells, compares the score against the threshold and
// forwards only cells that pass into the queue.
// ----------------------------------------------------------------------------
module abdt_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cell_valid,
    output logic               cell_stall,
    input  abdt_pkg::cell_t    cell_data,
    input  logic signed [15:0] threshold,
    input  logic               queue_full,
    output logic               push,
    output abdt_pkg::cell_t    push_cell
);

    logic            hold_vld_reg;
    logic            hold_vld_next;
    abdt_pkg::cell_t hold_cell_reg;
    logic            accept;
    logic            pass;

    // Holding register is busy only while a passing cell waits for room
    assign cell_stall = hold_vld_reg && queue_full;
    assign accept     = cell_valid && !cell_stall;
    assign push       = hold_vld_reg && !queue_full;
    assign push_cell  = hold_cell_reg;

    // Strict compare: a score equal to the threshold is dropped
    assign pass = $signed(cell_data.score_value) > threshold;

    always_comb
    begin
        hold_vld_next = hold_vld_reg;
        if (accept)
        begin
            hold_vld_next = pass;
        end
        else if (push)
        begin
            hold_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_vld_reg <= 1'b0;
        end
        else
        begin
            hold_vld_reg <= hold_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_cell_reg <= cell_data;
        end
    end

endmodule

### rtl/abdt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abdt_queue
// Small FIFO between front and back so each side can stall on its own.
// ----------------------------------------------------------------------------
module abdt_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  abdt_pkg::cell_t push_cell,
    output logic            full,
    input  logic            pop,
    output abdt_pkg::cell_t head,
    output logic            empty
);

    localparam int DEPTH = abdt_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    abdt_pkg::cell_t  mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full  = count_reg == CNT_W'(DEPTH);
    assign empty = count_reg == '0;
    assign head  = mem[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cell;
        end
    end

endmodule

### rtl/abdt_sigmoid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abdt_sigmoid
// Pipelined fixed-point sigmoid of score * 2^exponent, Q0.16 result.
// exp(-|x|) is built as a power of two: table for the high fraction bits,
// one multiply stage per low fraction bit, then a bit-per-stage divider.
// ----------------------------------------------------------------------------
module abdt_sigmoid (
    input  logic               clk,
    input  logic               en,
    input  logic signed [15:0] score,
    input  logic signed [4:0]  score_exponent,
    output logic [15:0]        confidence
);

    localparam int LO  = abdt_pkg::EXP_LO_STAGES;
    localparam int HI  = abdt_pkg::EXP_HI_BITS;
    localparam int DIV = abdt_pkg::DIV_STAGES;

    // Stage 1: magnitude, shift, clamp
    logic [15:0] mag;
    logic [4:0]  sh;
    logic [46:0] mq_full;
    logic [20:0] mq_next;
    logic [20:0] mq_reg;
    logic        neg_s1_reg;

    // Stage 2: scale by log2(e)
    logic [37:0] lg_prod;
    logic [20:0] b_reg;
    logic        neg_s2_reg;

    // Exp stages
    logic [32:0] exp_tab [abdt_pkg::EXP_TAB_SIZE];
    logic [32:0] acc_reg [LO+1];
    logic [LO-1:0] lo_reg [LO];
    logic [4:0]  ip_reg  [LO+1];
    logic        neg_reg [LO+1];

    // Divider setup
    logic [32:0] t_val;

    // Divider stages
    logic [33:0]  rem_reg [DIV];
    logic [33:0]  den_reg [DIV];
    logic [DIV-1:0] nb_reg [DIV];
    logic [DIV-1:0] quo_reg [DIV+1];

    // Stage 1 logic
    assign mag     = score[15] ? 16'(-score) : 16'(score);
    assign sh      = score_exponent ^ 5'b10000;
    assign mq_full = 47'(mag) << sh;
    assign mq_next = (mq_full > 47'(abdt_pkg::SIG_CLAMP)) ? abdt_pkg::SIG_CLAMP
                                                          : mq_full[20:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mq_reg     <= mq_next;
            neg_s1_reg <= score[15];
        end
    end

    // Stage 2 logic
    assign lg_prod = 38'(mq_reg) * 38'(abdt_pkg::LOG2E_Q16);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_reg      <= lg_prod[36:16];
            neg_s2_reg <= neg_s1_reg;
        end
    end

    // Constant table over the high fraction bits
    for (genvar g = 0; g < abdt_pkg::EXP_TAB_SIZE; g++)
    begin : g_tab
        localparam logic [32:0] ENTRY = abdt_pkg::exp2_hi(g);
        assign exp_tab[g] = ENTRY;
    end

    // Stage 3: table lookup
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc_reg[0] <= exp_tab[b_reg[15:16-HI]];
            lo_reg[0]  <= b_reg[LO-1:0];
            ip_reg[0]  <= b_reg[20:16];
            neg_reg[0] <= neg_s2_reg;
        end
    end

    // One floored multiply per low fraction bit, most significant first
    for (genvar j = 1; j <= LO; j++)
    begin : g_exp
        localparam logic [31:0] C = abdt_pkg::exp2_const(HI + j);
        logic [64:0] prod;

        assign prod = 65'(acc_reg[j-1]) * 65'(C);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                acc_reg[j] <= lo_reg[j-1][LO-j] ? prod[64:32] : acc_reg[j-1];
                ip_reg[j]  <= ip_reg[j-1];
                neg_reg[j] <= neg_reg[j-1];
            end
        end

        if (j < LO)
        begin : g_lo
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    lo_reg[j] <= lo_reg[j-1];
                end
            end
        end
    end

    // Divider setup: t = 2^-frac >> int, denominator 2^32 + t.
    // Positive score divides 2^48, negative divides t * 2^16; the upper
    // quotient bits are known zero, so the remainder starts at N >> 17.
    assign t_val = acc_reg[LO] >> ip_reg[LO];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg[0] <= 34'(t_val) + (34'd1 << 32);
            quo_reg[0] <= '0;
            if (neg_reg[LO])
            begin
                rem_reg[0] <= 34'(t_val[32:1]);
                nb_reg[0]  <= {t_val[0], (DIV-1)'(0)};
            end
            else
            begin
                rem_reg[0] <= 34'd1 << 31;
                nb_reg[0]  <= '0;
            end
        end
    end

    // Restoring divider, one quotient bit per stage
    for (genvar j = 1; j <= DIV; j++)
    begin : g_div
        logic [33:0] r2;
        logic        ge;

        assign r2 = {rem_reg[j-1][32:0], nb_reg[j-1][DIV-1]};
        assign ge = r2 >= den_reg[j-1];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[j] <= {quo_reg[j-1][DIV-2:0], ge};
            end
        end

        if (j < DIV)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j] <= ge ? r2 - den_reg[j-1] : r2;
                    den_reg[j] <= den_reg[j-1];
                    nb_reg[j]  <= nb_reg[j-1] << 1;
                end
            end
        end
    end

    // Only a zero exponent term on a positive score reaches 1.0
    assign confidence = quo_reg[DIV][16] ? 16'hFFFF : quo_reg[DIV][15:0];

endmodule

### rtl/abdt_corner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abdt_corner
// One box corner: (base + size * delta * 2^exp) * inv_resize / 4096,
// truncated toward zero and saturated to 16 bits. Five register stages.
// ----------------------------------------------------------------------------
module abdt_corner (
    input  logic               clk,
    input  logic               en,
    input  logic signed [17:0] base,
    input  logic [9:0]         size,
    input  logic signed [15:0] delta,
    input  logic signed [4:0]  box_exponent,
    input  logic [15:0]        inv,
    output logic signed [15:0] result
);

    // C1
    logic signed [26:0] prod_next;
    logic signed [26:0] prod_reg;
    logic signed [17:0] base_reg;

    // C2
    logic [4:0]         sh;
    logic signed [58:0] n_next;
    logic signed [58:0] n_reg;

    // C3
    logic [58:0] mag;
    logic        neg_c3_reg;
    logic        big_c3_reg;
    logic [43:0] m44_reg;

    // C4
    logic [37:0] phi_reg;
    logic [37:0] plo_reg;
    logic        neg_c4_reg;
    logic        big_c4_reg;

    // C5
    logic [59:0] p;
    logic [31:0] q;
    logic        sat;
    logic signed [15:0] result_next;
    logic signed [15:0] result_reg;

    // C1: anchor size times delta
    assign prod_next = $signed({1'b0, size}) * delta;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            base_reg <= base;
        end
    end

    // C2: exact sum in units of 2^-16
    assign sh     = box_exponent ^ 5'b10000;
    assign n_next = (59'(base_reg) <<< 16) + (59'(prod_reg) <<< sh);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg <= n_next;
        end
    end

    // C3: magnitude; anything at or above 2^44 saturates for any nonzero scale
    assign mag = n_reg[58] ? 59'(-n_reg) : 59'(n_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_c3_reg <= n_reg[58];
            big_c3_reg <= |mag[58:44];
            m44_reg    <= mag[43:0];
        end
    end

    // C4: scale by the reciprocal resize in two halves
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            phi_reg    <= 38'(m44_reg[43:22]) * 38'(inv);
            plo_reg    <= 38'(m44_reg[21:0]) * 38'(inv);
            neg_c4_reg <= neg_c3_reg;
            big_c4_reg <= big_c3_reg;
        end
    end

    // C5: recombine, drop 28 fraction bits, saturate
    assign p = (60'(phi_reg) << 22) + 60'(plo_reg);
    assign q = p[59:28];

    always_comb
    begin
        if (neg_c4_reg)
        begin
            sat         = (big_c4_reg && (inv != '0)) || (q > 32'd32768);
            result_next = sat ? 16'sh8000 : $signed(16'(16'd0 - q[15:0]));
        end
        else
        begin
            sat         = (big_c4_reg && (inv != '0)) || (q > 32'd32767);
            result_next = sat ? 16'sh7FFF : $signed(q[15:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

### rtl/abdt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abdt_back
// Execution pipeline: pops passing cells from the queue, decodes the four
// corners and the confidence, and holds the finished box in the output
// register. The whole pipeline advances unless the output is stalled.
// ----------------------------------------------------------------------------
module abdt_back #(
    parameter int DELTA_BITS = abdt_pkg::DELTA_BITS
) (
    input  logic            clk,
    input  logic            rst_n,
    input  abdt_pkg::cell_t head,
    input  logic            empty,
    output logic            pop,
    input  abdt_pkg::cfg_t  cfg,
    output logic            box_valid,
    input  logic            box_stall,
    output abdt_pkg::box_t  box
);

    localparam int SIG_LAT = abdt_pkg::SIG_LAT;
    localparam int DLY     = abdt_pkg::SIG_LAT - abdt_pkg::BOX_LAT;
    localparam int DSH     = 16 - DELTA_BITS;

    logic adv;

    logic [SIG_LAT-1:0] vld_reg;
    logic               box_valid_reg;
    abdt_pkg::box_t     box_reg;
    abdt_pkg::box_t     box_next;

    // Stage B1: centers and lane deltas
    logic [15:0]        cx_reg;
    logic [15:0]        cy_reg;
    logic [9:0]         aw_reg;
    logic [9:0]         ah_reg;
    logic signed [15:0] delta_next [4];
    logic signed [15:0] delta_reg  [4];

    logic signed [17:0] base_lx;
    logic signed [17:0] base_rx;
    logic signed [17:0] base_ty;
    logic signed [17:0] base_by;

    logic signed [15:0] corner_res [4];
    logic [63:0]        corner_dly_reg [DLY];
    logic [7:0]         cat_dly_reg [SIG_LAT];
    logic [15:0]        confidence;

    // Global advance: everything moves unless a result is waiting
    assign adv = !box_valid_reg || !box_stall;
    assign pop = adv && !empty;

    // Valid tracking along the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            box_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[SIG_LAT-2:0], pop};
            box_valid_reg <= vld_reg[SIG_LAT-1];
        end
    end

    // Each lane keeps only its low DELTA_BITS bits as a signed delta
    for (genvar k = 0; k < 4; k++)
    begin : g_lane
        logic [15:0] lane_shl;
        assign lane_shl      = head.box_deltas[16*k +: 16] << DSH;
        assign delta_next[k] = $signed(lane_shl) >>> DSH;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cx_reg <= 16'(head.grid_x) * 16'(head.step_x) + 16'(head.center_off_x);
            cy_reg <= 16'(head.grid_y) * 16'(head.step_y) + 16'(head.center_off_y);
            aw_reg <= head.anc_width;
            ah_reg <= head.anc_height;
            for (int k = 0; k < 4; k++)
            begin
                delta_reg[k] <= delta_next[k];
            end
        end
    end

    // Anchor bases: the lower edge takes floor(size/2), the upper edge the rest
    assign base_lx = $signed({2'b00, cx_reg}) - $signed({8'd0, aw_reg >> 1});
    assign base_rx = $signed({2'b00, cx_reg}) + $signed({8'd0, aw_reg})
                   - $signed({8'd0, aw_reg >> 1});
    assign base_ty = $signed({2'b00, cy_reg}) - $signed({8'd0, ah_reg >> 1});
    assign base_by = $signed({2'b00, cy_reg}) + $signed({8'd0, ah_reg})
                   - $signed({8'd0, ah_reg >> 1});

    abdt_corner u_left (
        .clk          (clk),
        .en           (adv),
        .base         (base_lx),
        .size         (aw_reg),
        .delta        (delta_reg[0]),
        .box_exponent (cfg.box_exponent),
        .inv          (cfg.inv_resize_x),
        .result       (corner_res[0])
    );

    abdt_corner u_top (
        .clk          (clk),
        .en           (adv),
        .base         (base_ty),
        .size         (ah_reg),
        .delta        (delta_reg[1]),
        .box_exponent (cfg.box_exponent),
        .inv          (cfg.inv_resize_y),
        .result       (corner_res[1])
    );

    abdt_corner u_right (
        .clk          (clk),
        .en           (adv),
        .base         (base_rx),
        .size         (aw_reg),
        .delta        (delta_reg[2]),
        .box_exponent (cfg.box_exponent),
        .inv          (cfg.inv_resize_x),
        .result       (corner_res[2])
    );

    abdt_corner u_bottom (
        .clk          (clk),
        .en           (adv),
        .base         (base_by),
        .size         (ah_reg),
        .delta        (delta_reg[3]),
        .box_exponent (cfg.box_exponent),
        .inv          (cfg.inv_resize_y),
        .result       (corner_res[3])
    );

    abdt_sigmoid u_sigmoid (
        .clk            (clk),
        .en             (adv),
        .score          (head.score_value),
        .score_exponent (cfg.score_exponent),
        .confidence     (confidence)
    );

    // Align the short box path and the category with the sigmoid path
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            corner_dly_reg[0] <= {corner_res[3], corner_res[2],
                                  corner_res[1], corner_res[0]};
            for (int i = 1; i < DLY; i++)
            begin
                corner_dly_reg[i] <= corner_dly_reg[i-1];
            end
            cat_dly_reg[0] <= head.category;
            for (int i = 1; i < SIG_LAT; i++)
            begin
                cat_dly_reg[i] <= cat_dly_reg[i-1];
            end
        end
    end

    // Output register
    always_comb
    begin
        box_next.box_category = cat_dly_reg[SIG_LAT-1];
        box_next.confidence   = confidence;
        box_next.left         = $signed(corner_dly_reg[DLY-1][15:0]);
        box_next.top          = $signed(corner_dly_reg[DLY-1][31:16]);
        box_next.right        = $signed(corner_dly_reg[DLY-1][47:32]);
        box_next.bottom       = $signed(corner_dly_reg[DLY-1][63:48]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            box_reg <= box_next;
        end
    end

    assign box_valid = box_valid_reg;
    assign box       = box_reg;

endmodule

### rtl/anchor_box_decode_threshold.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anchor_box_decode_threshold
// Decodes one detector output cell per transaction into a scored box when the
// score is above the programmed threshold; cells at or below it vanish.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+---------------------------
//   cell     | in        | cell_valid/cell_stall| cell_data, abdt_pkg::cell_t
//   box      | out       | box_valid/box_stall  | box, abdt_pkg::box_t
//   cfg      | in        | cfg_wr_en            | cfg_index, cfg_data
//
// Throughput is one cell per cycle unless a box stall holds the flow. A passing
// cell reaches box_valid via the holding register, a queue slot, the 29-stage back
// pipeline (8 exponent multiply steps, 17-step divider) and the output register.
// Reset clears the pipeline valids, the queue and loads the register defaults.
// A box stall freezes the back pipeline; the 4-entry queue and the input
// holding register then absorb cells before cell_stall rises.
// ----------------------------------------------------------------------------
module anchor_box_decode_threshold #(
    parameter int DELTA_BITS = abdt_pkg::DELTA_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cell_valid,
    output logic                                cell_stall,
    input  abdt_pkg::cell_t                     cell_data,
    output logic                                box_valid,
    input  logic                                box_stall,
    output abdt_pkg::box_t                      box,
    input  logic                                cfg_wr_en,
    input  logic [abdt_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [abdt_pkg::CFG_DATA_W-1:0]     cfg_data
);

    abdt_pkg::cfg_t  cfg_reg;
    abdt_pkg::cfg_t  cfg_next;

    logic            push;
    abdt_pkg::cell_t push_cell;
    logic            queue_full;
    logic            pop;
    logic            queue_empty;
    abdt_pkg::cell_t head;

    // Configuration register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                abdt_pkg::REG_THRESH_Q:        cfg_next.thresh_q       = $signed(cfg_data);
                abdt_pkg::REG_SCORE_EXPONENT:  cfg_next.score_exponent = $signed(cfg_data[4:0]);
                abdt_pkg::REG_BOX_EXPONENT:    cfg_next.box_exponent   = $signed(cfg_data[4:0]);
                abdt_pkg::REG_INV_RESIZE_X:    cfg_next.inv_resize_x   = cfg_data;
                abdt_pkg::REG_INV_RESIZE_Y:    cfg_next.inv_resize_y   = cfg_data;
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.thresh_q        <= '0;
            cfg_reg.score_exponent  <= '0;
            cfg_reg.box_exponent    <= '0;
            cfg_reg.inv_resize_x    <= abdt_pkg::INV_RESIZE_ONE;
            cfg_reg.inv_resize_y    <= abdt_pkg::INV_RESIZE_ONE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    abdt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cell_valid (cell_valid),
        .cell_stall (cell_stall),
        .cell_data  (cell_data),
        .threshold  (cfg_reg.thresh_q),
        .queue_full (queue_full),
        .push       (push),
        .push_cell  (push_cell)
    );

    abdt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cell (push_cell),
        .full      (queue_full),
        .pop       (pop),
        .head      (head),
        .empty     (queue_empty)
    );

    abdt_back #(
        .DELTA_BITS (DELTA_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (queue_empty),
        .pop       (pop),
        .cfg       (cfg_reg),
        .box_valid (box_valid),
        .box_stall (box_stall),
        .box       (box)
    );

endmodule
